// ===== hdl/icrt_pkg.sv =====
// Shared types, constants and helper functions of the interval reservation table.
package icrt_pkg;

    localparam int CAPACITY = 256;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int POS_W    = 8;
    localparam int SLOT_W   = 8;
    localparam int COUNT_W  = 9;
    localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

    localparam int START_W  = 11;
    localparam int END_W    = 17;
    localparam int MIN_PER_HOUR = 60;

    localparam logic [5:0] DAY_MAX    = 6'd31;
    localparam logic [3:0] MONTH_MAX  = 4'd12;
    localparam logic [4:0] HOUR_MAX   = 5'd23;
    localparam logic [5:0] MINUTE_MAX = 6'd59;

    localparam logic OP_ADD    = 1'b0;
    localparam logic OP_DELETE = 1'b1;

    typedef enum logic [2:0] {
        ST_ADDED    = 3'd0,
        ST_CONFLICT = 3'd1,
        ST_INVALID  = 3'd2,
        ST_FULL     = 3'd3,
        ST_BADPOS   = 3'd4,
        ST_DELETED  = 3'd5,
        ST_EMPTY    = 3'd6
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_RESP
    } state_t;

    typedef struct packed {
        logic [5:0]  day;
        logic [3:0]  month;
        logic [13:0] year;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [15:0] length;
    } entry_t;

    // Start of an interval in minutes after midnight.
    function automatic logic [START_W-1:0] start_of(input logic [4:0] hour,
                                                     input logic [5:0] minute);
        start_of = START_W'(hour) * START_W'(MIN_PER_HOUR) + START_W'(minute);
    endfunction

    // End of an interval in minutes after midnight.
    function automatic logic [END_W-1:0] end_of(input logic [START_W-1:0] start,
                                                 input logic [15:0] length);
        end_of = END_W'(start) + END_W'(length);
    endfunction

endpackage

// ===== hdl/icrt_overlap.sv =====
// Date match and interval overlap compare between a new booking and a stored one.
module icrt_overlap
(
    input  icrt_pkg::entry_t                   new_entry,
    input  logic [icrt_pkg::START_W-1:0]       new_start,
    input  logic [icrt_pkg::END_W-1:0]         new_end,
    input  icrt_pkg::entry_t                   old_entry,
    output logic                               hit
);

    logic [icrt_pkg::START_W-1:0] old_start;
    logic [icrt_pkg::END_W-1:0]   old_end;
    logic                         same_date;

    assign old_start = icrt_pkg::start_of(old_entry.hour, old_entry.minute);
    assign old_end   = icrt_pkg::end_of(old_start, old_entry.length);

    assign same_date = (old_entry.day == new_entry.day)
                    && (old_entry.month == new_entry.month)
                    && (old_entry.year == new_entry.year);

    // Half-open intervals: a zero-length booking overlaps only one that strictly surrounds it.
    assign hit = same_date
              && (icrt_pkg::END_W'(new_start) < old_end)
              && (new_end > icrt_pkg::END_W'(old_start));

endmodule

// ===== hdl/interval_conflict_reservation_table.sv =====
// Top level of the interval reservation table: sequencer, booking memory and result register.
// Sequence: full, invalid, empty, bad position and an add to an empty table go from the idle
// state straight to the response state and from there into the output register. An add scans
// the stored entries and stops at the first conflict or after the last one; a delete walks
// the entries above its position down by one, one entry per cycle through the one read port.
// Flow: one item at a time; the input stalls until the result enters the output register.
// Reset: rst_n clears the count, the sequencer and out_valid; the memory is left as it is.
module interval_conflict_reservation_table
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic        operation,
    input  logic [5:0]  day,
    input  logic [3:0]  month,
    input  logic [13:0] year,
    input  logic [4:0]  hour,
    input  logic [5:0]  minute,
    input  logic [15:0] length_minutes,
    input  logic [7:0]  position,

    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  status,
    output logic [7:0]  slot,
    output logic [8:0]  entry_count
);

    // Sequencer state and entry count.
    icrt_pkg::state_t                state_reg, state_next;
    logic [icrt_pkg::CNT_W-1:0]      count_reg, count_next;

    // The add item under work and its interval bounds.
    icrt_pkg::entry_t                item_reg, item_next;
    logic [icrt_pkg::START_W-1:0]    new_start_reg, new_start_next;
    logic [icrt_pkg::END_W-1:0]      new_end_reg, new_end_next;

    // Scan and shift walk. The walk index can reach the count itself, so it is
    // count-wide and addresses the memory through a part-select.
    logic [icrt_pkg::CNT_W-1:0]      walk_reg, walk_next;
    logic                            rd_valid_reg, rd_valid_next;
    logic [icrt_pkg::IDX_W-1:0]      rd_idx_reg, rd_idx_next;

    // Result waiting for the output register.
    icrt_pkg::status_t               pend_status_reg, pend_status_next;
    logic [icrt_pkg::SLOT_W-1:0]     pend_slot_reg, pend_slot_next;

    // Output register.
    logic                            out_valid_reg, out_valid_next;
    icrt_pkg::status_t               out_status_reg, out_status_next;
    logic [icrt_pkg::SLOT_W-1:0]     out_slot_reg, out_slot_next;
    logic [icrt_pkg::COUNT_W-1:0]    out_count_reg, out_count_next;

    // Booking memory: one write and one registered read per cycle.
    icrt_pkg::entry_t                booking_store_reg [icrt_pkg::CAPACITY];
    icrt_pkg::entry_t                rd_data_reg;
    logic                            mem_we;
    logic [icrt_pkg::IDX_W-1:0]      mem_waddr;
    icrt_pkg::entry_t                mem_wdata;
    logic [icrt_pkg::IDX_W-1:0]      mem_raddr;

    logic                            accept;
    logic                            out_free;
    icrt_pkg::entry_t                in_entry;
    logic                            in_full;
    logic                            in_bad_field;
    logic [icrt_pkg::CMP_W-1:0]      pos_wide;
    logic [icrt_pkg::CMP_W-1:0]      count_wide;
    logic                            hit;
    logic                            last_compared;
    logic                            walk_more;

    assign in_entry.day    = day;
    assign in_entry.month  = month;
    assign in_entry.year   = year;
    assign in_entry.hour   = hour;
    assign in_entry.minute = minute;
    assign in_entry.length = length_minutes;

    assign accept   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    assign in_full      = (count_reg >= icrt_pkg::CNT_W'(icrt_pkg::CAPACITY));
    assign in_bad_field = (day > icrt_pkg::DAY_MAX) || (month > icrt_pkg::MONTH_MAX)
                       || (hour > icrt_pkg::HOUR_MAX) || (minute > icrt_pkg::MINUTE_MAX);
    assign pos_wide     = icrt_pkg::CMP_W'(position);
    assign count_wide   = icrt_pkg::CMP_W'(count_reg);

    // The stored entry read last cycle is compared against the new booking.
    icrt_overlap u_overlap
    (
        .new_entry (item_reg),
        .new_start (new_start_reg),
        .new_end   (new_end_reg),
        .old_entry (rd_data_reg),
        .hit       (hit)
    );

    assign last_compared = rd_valid_reg
                        && (icrt_pkg::CNT_W'(rd_idx_reg) == count_reg - icrt_pkg::CNT_W'(1));
    assign walk_more     = (walk_reg < count_reg);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            icrt_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    if (operation == icrt_pkg::OP_ADD)
                    begin
                        if (!in_full && !in_bad_field && (count_reg != '0))
                        begin
                            state_next = icrt_pkg::S_SCAN;
                        end
                        else
                        begin
                            state_next = icrt_pkg::S_RESP;
                        end
                    end
                    else if ((count_reg != '0) && (pos_wide < count_wide))
                    begin
                        state_next = icrt_pkg::S_SHIFT;
                    end
                    else
                    begin
                        state_next = icrt_pkg::S_RESP;
                    end
                end
            end
            icrt_pkg::S_SCAN:
            begin
                if ((rd_valid_reg && hit) || last_compared)
                begin
                    state_next = icrt_pkg::S_RESP;
                end
            end
            icrt_pkg::S_SHIFT:
            begin
                if (!walk_more)
                begin
                    state_next = icrt_pkg::S_RESP;
                end
            end
            icrt_pkg::S_RESP:
            begin
                if (out_free)
                begin
                    state_next = icrt_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = icrt_pkg::S_IDLE;
            end
        endcase
    end

    // Datapath, memory control and outputs of the sequencer.
    always_comb
    begin
        count_next       = count_reg;
        item_next        = item_reg;
        new_start_next   = new_start_reg;
        new_end_next     = new_end_reg;
        walk_next        = walk_reg;
        rd_valid_next    = 1'b0;
        rd_idx_next      = rd_idx_reg;
        pend_status_next = pend_status_reg;
        pend_slot_next   = pend_slot_reg;
        out_valid_next   = out_valid_reg && out_stall;
        out_status_next  = out_status_reg;
        out_slot_next    = out_slot_reg;
        out_count_next   = out_count_reg;
        mem_we           = 1'b0;
        mem_waddr        = count_reg[icrt_pkg::IDX_W-1:0];
        mem_wdata        = item_reg;
        mem_raddr        = walk_reg[icrt_pkg::IDX_W-1:0];
        in_stall         = (state_reg != icrt_pkg::S_IDLE);

        unique case (state_reg)
            icrt_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    item_next      = in_entry;
                    new_start_next = icrt_pkg::start_of(hour, minute);
                    new_end_next   = icrt_pkg::end_of(new_start_next, length_minutes);
                    pend_slot_next = '0;
                    walk_next      = '0;
                    if (operation == icrt_pkg::OP_ADD)
                    begin
                        if (in_full)
                        begin
                            pend_status_next = icrt_pkg::ST_FULL;
                        end
                        else if (in_bad_field)
                        begin
                            pend_status_next = icrt_pkg::ST_INVALID;
                        end
                        else if (count_reg == '0)
                        begin
                            // Nothing to scan: the booking goes straight to position 0.
                            mem_we           = 1'b1;
                            mem_waddr        = '0;
                            mem_wdata        = in_entry;
                            count_next       = icrt_pkg::CNT_W'(1);
                            pend_status_next = icrt_pkg::ST_ADDED;
                        end
                    end
                    else
                    begin
                        if (count_reg == '0)
                        begin
                            pend_status_next = icrt_pkg::ST_EMPTY;
                        end
                        else if (pos_wide >= count_wide)
                        begin
                            pend_status_next = icrt_pkg::ST_BADPOS;
                        end
                        else
                        begin
                            // Entries from position + 1 upward each move down by one.
                            walk_next = icrt_pkg::CNT_W'(pos_wide + icrt_pkg::CMP_W'(1));
                        end
                    end
                end
            end
            icrt_pkg::S_SCAN:
            begin
                if (rd_valid_reg && hit)
                begin
                    pend_status_next = icrt_pkg::ST_CONFLICT;
                    pend_slot_next   = icrt_pkg::SLOT_W'(rd_idx_reg);
                end
                else if (last_compared)
                begin
                    mem_we           = 1'b1;
                    pend_status_next = icrt_pkg::ST_ADDED;
                    pend_slot_next   = icrt_pkg::SLOT_W'(count_reg);
                    count_next       = count_reg + icrt_pkg::CNT_W'(1);
                end
                else if (walk_more)
                begin
                    rd_valid_next = 1'b1;
                    rd_idx_next   = walk_reg[icrt_pkg::IDX_W-1:0];
                    walk_next     = walk_reg + icrt_pkg::CNT_W'(1);
                end
            end
            icrt_pkg::S_SHIFT:
            begin
                // The entry read last cycle lands one position lower.
                if (rd_valid_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = rd_idx_reg;
                    mem_wdata = rd_data_reg;
                end
                if (walk_more)
                begin
                    rd_valid_next = 1'b1;
                    rd_idx_next   = icrt_pkg::IDX_W'(walk_reg - icrt_pkg::CNT_W'(1));
                    walk_next     = walk_reg + icrt_pkg::CNT_W'(1);
                end
                else
                begin
                    count_next       = count_reg - icrt_pkg::CNT_W'(1);
                    pend_status_next = icrt_pkg::ST_DELETED;
                end
            end
            icrt_pkg::S_RESP:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = pend_status_reg;
                    out_slot_next   = pend_slot_reg;
                    out_count_next  = icrt_pkg::COUNT_W'(count_reg);
                end
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= icrt_pkg::S_IDLE;
            count_reg     <= '0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rd_valid_reg  <= rd_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg        <= item_next;
        new_start_reg   <= new_start_next;
        new_end_reg     <= new_end_next;
        walk_reg        <= walk_next;
        rd_idx_reg      <= rd_idx_next;
        pend_status_reg <= pend_status_next;
        pend_slot_reg   <= pend_slot_next;
        out_status_reg  <= out_status_next;
        out_slot_reg    <= out_slot_next;
        out_count_reg   <= out_count_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            booking_store_reg[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= booking_store_reg[mem_raddr];
    end

    assign out_valid   = out_valid_reg;
    assign status      = out_status_reg;
    assign slot        = out_slot_reg;
    assign entry_count = out_count_reg;

endmodule

// ===== hdl/icrt_checker.sv =====
// Port-level checker of the interval reservation table and its bind.
module icrt_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [2:0]  status,
    input logic [7:0]  slot,
    input logic [8:0]  entry_count
);

    // The block works on one item at a time, so it stalls right after a transfer.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input not stalled after a transfer");

    // A stalled result holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(status) && $stable(slot)
                                      && $stable(entry_count)))
        else $error("stalled result changed");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (entry_count <= 9'(icrt_pkg::CAPACITY)))
        else $error("entry count beyond capacity");

    // An added booking always lands at the end of the packed table.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == icrt_pkg::ST_ADDED))
            |-> ({1'b0, slot} == entry_count - 9'd1))
        else $error("added slot is not the last entry");

    // A conflict points at a stored entry.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == icrt_pkg::ST_CONFLICT)) |-> ({1'b0, slot} < entry_count))
        else $error("conflict slot beyond entry count");

endmodule

bind interval_conflict_reservation_table icrt_checker u_icrt_checker (.*);

// ===== verif/interval_conflict_reservation_table_tb.sv =====
// Self-checking testbench for the interval reservation table, directed table then random traffic.
`timescale 1ns / 1ps

module interval_conflict_reservation_table_tb;

    // Run shape. The random part fills the table to capacity, hammers it while it is
    // full, then drains it again, so the scan and the shift see every table size.
    localparam int NUM_DIRECTED      = 25;
    localparam int RANDOM_ITEMS      = 750;
    localparam int AT_CAPACITY_ITEMS = 60;
    localparam int SHOWN_MISMATCHES  = 10;

    // Slowest correct run: about 775 items, each taking up to a full scan of the table, plus
    // sender gaps and receiver stalls. The limit is several times that.
    localparam int CYCLE_LIMIT = 1_000_000;

    // One input transfer, one field per port.
    typedef struct packed {
        logic        operation;
        logic [5:0]  day;
        logic [3:0]  month;
        logic [13:0] year;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [15:0] length_minutes;
        logic [7:0]  position;
    } booking_req_t;

    // One result transfer.
    typedef struct packed {
        icrt_pkg::status_t status;
        logic [7:0]        slot;
        logic [8:0]        entry_count;
    } booking_resp_t;

    // A row of the directed table. Where has_answer is set, the answer is typed in by
    // hand; otherwise the row is checked against the predictor like random traffic.
    typedef struct packed {
        bit            has_answer;
        booking_resp_t answer;
        booking_req_t  req;
    } directed_row_t;

    typedef enum logic [1:0] {
        LOAD_FILLING,
        LOAD_AT_CAPACITY,
        LOAD_DRAINING
    } load_phase_t;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_SPARSE,
        STALL_HEAVY
    } stall_mode_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        operation;
    logic [5:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [15:0] length_minutes;
    logic [7:0]  position;
    logic        out_valid;
    logic        out_stall;
    logic [2:0]  status;
    logic [7:0]  slot;
    logic [8:0]  entry_count;

    // Predictor state: a private copy of the booking table and its fill level.
    icrt_pkg::entry_t booked [icrt_pkg::CAPACITY];
    int               booked_count;
    bit               reached_full;

    // Results still owed by the block, oldest first.
    booking_resp_t answers_due [$];

    int mismatch_count = 0;
    int cycle_count    = 0;
    int burst_left     = 0;

    interval_conflict_reservation_table u_top
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .operation      (operation),
        .day            (day),
        .month          (month),
        .year           (year),
        .hour           (hour),
        .minute         (minute),
        .length_minutes (length_minutes),
        .position       (position),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .slot           (slot),
        .entry_count    (entry_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog: a hung handshake or a lost result ends the run here.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Works out the result of one accepted item and updates the private table.
    // An add is checked for a full table first, then for fields out of range, then
    // for overlap with bookings on the same date. Intervals are half open, so a
    // booking that ends exactly where another starts does not collide, and a
    // zero-length booking collides only with one that strictly surrounds its start.
    task automatic predict_outcome(input booking_req_t r, output booking_resp_t e);
        int new_start;
        int new_end;
        int old_start;
        int old_end;
        int k;
        bit hit;
        e        = '0;
        e.status = icrt_pkg::ST_ADDED;
        hit      = 1'b0;
        if (r.operation == icrt_pkg::OP_ADD)
        begin
            if (booked_count >= icrt_pkg::CAPACITY)
            begin
                e.status = icrt_pkg::ST_FULL;
            end
            else if (r.day > icrt_pkg::DAY_MAX || r.month > icrt_pkg::MONTH_MAX ||
                     r.hour > icrt_pkg::HOUR_MAX || r.minute > icrt_pkg::MINUTE_MAX)
            begin
                e.status = icrt_pkg::ST_INVALID;
            end
            else
            begin
                new_start = int'(r.hour) * icrt_pkg::MIN_PER_HOUR + int'(r.minute);
                new_end   = new_start + int'(r.length_minutes);
                for (k = 0; k < booked_count && !hit; k++)
                begin
                    old_start = int'(booked[k].hour) * icrt_pkg::MIN_PER_HOUR
                              + int'(booked[k].minute);
                    old_end   = old_start + int'(booked[k].length);
                    if (booked[k].day == r.day && booked[k].month == r.month &&
                        booked[k].year == r.year &&
                        new_start < old_end && new_end > old_start)
                    begin
                        hit    = 1'b1;
                        e.slot = 8'(k);
                    end
                end
                if (hit)
                begin
                    e.status = icrt_pkg::ST_CONFLICT;
                end
                else
                begin
                    booked[booked_count] = '{day: r.day, month: r.month, year: r.year,
                                             hour: r.hour, minute: r.minute,
                                             length: r.length_minutes};
                    e.slot = 8'(booked_count);
                    booked_count++;
                end
            end
        end
        else
        begin
            if (booked_count == 0)
            begin
                e.status = icrt_pkg::ST_EMPTY;
            end
            else if (int'(r.position) >= booked_count)
            begin
                e.status = icrt_pkg::ST_BADPOS;
            end
            else
            begin
                // The table stays packed: every later booking moves down by one.
                for (k = int'(r.position); k + 1 < booked_count; k++)
                begin
                    booked[k] = booked[k + 1];
                end
                booked_count--;
                e.status = icrt_pkg::ST_DELETED;
            end
        end
        e.entry_count = 9'(booked_count);
        if (booked_count == icrt_pkg::CAPACITY)
        begin
            reached_full = 1'b1;
        end
    endtask

    // Presents one item from a falling edge and holds it until the block takes it.
    // The predictor runs at the accepting edge, so expectations queue in transfer order.
    // Returns at the following falling edge with in_valid still high.
    task automatic send_transfer(input booking_req_t r, input bit has_answer,
                                 input booking_resp_t answer);
        booking_resp_t predicted;
        in_valid       <= 1'b1;
        operation      <= r.operation;
        day            <= r.day;
        month          <= r.month;
        year           <= r.year;
        hour           <= r.hour;
        minute         <= r.minute;
        length_minutes <= r.length_minutes;
        position       <= r.position;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        predict_outcome(r, predicted);
        answers_due.insert(answers_due.size(), has_answer ? answer : predicted);
        @(negedge clk);
    endtask

    // The sender works in bursts. Inside a burst valid stays high from item to item;
    // at the end of a burst it drops for a random gap, and sometimes the next burst
    // follows with no gap at all.
    task automatic sender_pause();
        int gap;
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(0, 15);
        end
    endtask

    // Builds one random item. Most adds are well formed: some land on a small pool of
    // busy dates so that overlaps come up often, the rest on random dates so that the
    // table can fill. A few adds carry a field out of range. Deletes mostly hit a
    // stored position, now and then any position at all.
    task automatic make_random_request(input load_phase_t phase, output booking_req_t r);
        int add_weight;
        int pick;
        int pool_index;
        r.operation      = icrt_pkg::OP_DELETE;
        r.day            = 6'($urandom_range(0, 63));
        r.month          = 4'($urandom_range(0, 15));
        r.year           = 14'($urandom_range(0, 16383));
        r.hour           = 5'($urandom_range(0, 31));
        r.minute         = 6'($urandom_range(0, 63));
        r.length_minutes = 16'($urandom_range(0, 65535));
        r.position       = 8'($urandom_range(0, 255));
        case (phase)
            LOAD_FILLING:     add_weight = 92;
            LOAD_AT_CAPACITY: add_weight = 80;
            default:          add_weight = 30;
        endcase
        if ($urandom_range(0, 99) < add_weight)
        begin
            r.operation = icrt_pkg::OP_ADD;
            if ($urandom_range(0, 99) < 30)
            begin
                pool_index = $urandom_range(0, 3);
                r.day      = 6'(pool_index * 7 + 1);
                r.month    = 4'(pool_index + 1);
                r.year     = 14'(2000 + pool_index);
            end
            else
            begin
                r.day   = 6'($urandom_range(0, 31));
                r.month = 4'($urandom_range(0, 12));
            end
            r.hour   = 5'($urandom_range(0, 23));
            r.minute = 6'($urandom_range(0, 59));
            pick     = $urandom_range(0, 99);
            if (pick < 10)
            begin
                r.length_minutes = '0;
            end
            else if (pick < 92)
            begin
                r.length_minutes = 16'($urandom_range(1, 240));
            end
            if ($urandom_range(0, 99) < 8)
            begin
                case ($urandom_range(0, 4))
                    0: r.day    = 6'($urandom_range(32, 63));
                    1: r.month  = 4'($urandom_range(13, 15));
                    2: r.hour   = 5'($urandom_range(24, 31));
                    3: r.minute = 6'($urandom_range(60, 63));
                    default:
                    begin
                        r.day    = 6'($urandom_range(32, 63));
                        r.month  = 4'($urandom_range(13, 15));
                        r.hour   = 5'($urandom_range(24, 31));
                        r.minute = 6'($urandom_range(60, 63));
                    end
                endcase
            end
        end
        else if (booked_count > 0 && $urandom_range(0, 99) < 80)
        begin
            r.position = 8'($urandom_range(0, booked_count - 1));
        end
    endtask

    function automatic directed_row_t add_row(input logic [5:0] d, input logic [3:0] mo,
                                              input logic [13:0] yr, input logic [4:0] hr,
                                              input logic [5:0] mi, input logic [15:0] len,
                                              input bit known = 1'b0,
                                              input icrt_pkg::status_t st =
                                                  icrt_pkg::ST_ADDED,
                                              input logic [7:0] sl = '0,
                                              input logic [8:0] cnt = '0);
        directed_row_t row;
        row                    = '0;
        row.req.operation      = icrt_pkg::OP_ADD;
        row.req.day            = d;
        row.req.month          = mo;
        row.req.year           = yr;
        row.req.hour           = hr;
        row.req.minute         = mi;
        row.req.length_minutes = len;
        row.has_answer         = known;
        row.answer.status      = st;
        row.answer.slot        = sl;
        row.answer.entry_count = cnt;
        return row;
    endfunction

    function automatic directed_row_t del_row(input logic [7:0] pos,
                                              input bit known = 1'b0,
                                              input icrt_pkg::status_t st =
                                                  icrt_pkg::ST_DELETED,
                                              input logic [7:0] sl = '0,
                                              input logic [8:0] cnt = '0);
        directed_row_t row;
        row                    = '0;
        row.req.operation      = icrt_pkg::OP_DELETE;
        row.req.position       = pos;
        row.has_answer         = known;
        row.answer.status      = st;
        row.answer.slot        = sl;
        row.answer.entry_count = cnt;
        return row;
    endfunction

    // Receiver: stretches of no stall, sparse stalls and heavy stalls, each of random
    // length, so that results back up against the block at every stage of its work.
    initial
    begin : receiver_stall
        stall_mode_t mode;
        int          run;
        out_stall = 1'b0;
        forever
        begin
            mode = stall_mode_t'($urandom_range(0, 2));
            run  = $urandom_range(4, 40);
            repeat (run)
            begin
                @(negedge clk);
                case (mode)
                    STALL_NONE:   out_stall <= 1'b0;
                    STALL_SPARSE: out_stall <= ($urandom_range(0, 2) == 0);
                    default:      out_stall <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    // Result checker: every result taken from the block is compared with the oldest
    // expectation. A result with nothing owed counts as a failure as well.
    always @(posedge clk)
    begin : result_check
        booking_resp_t due;
        if (rst_n && out_valid && !out_stall)
        begin
            if (answers_due.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= SHOWN_MISMATCHES)
                begin
                    $display("%0t: result with nothing owed: status %0d slot %0d count %0d",
                             $realtime, status, slot, entry_count);
                end
            end
            else
            begin
                due = answers_due.pop_front();
                if (status !== due.status || slot !== due.slot ||
                    entry_count !== due.entry_count)
                begin
                    mismatch_count++;
                    if (mismatch_count <= SHOWN_MISMATCHES)
                    begin
                        $display("%0t: expected status %0d slot %0d count %0d, got %0d %0d %0d",
                                 $realtime, due.status, due.slot, due.entry_count,
                                 status, slot, entry_count);
                    end
                end
            end
        end
    end

    initial
    begin : stimulus
        directed_row_t directed_rows [NUM_DIRECTED];
        booking_req_t  req;
        load_phase_t   phase;
        int            items_since_full;
        int            i;

        // Every input is known from time zero, with reset held low.
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        operation      = icrt_pkg::OP_ADD;
        day            = '0;
        month          = '0;
        year           = '0;
        hour           = '0;
        minute         = '0;
        length_minutes = '0;
        position       = '0;
        booked_count   = 0;
        reached_full   = 1'b0;
        items_since_full = 0;

        // Directed part. Rows with a typed answer are the ones that follow straight
        // from the rules: deletes on an empty table, the all-maximum booking, each field
        // out of range alone and all at once, and the all-zero booking. The rest cover
        // a zero-length booking on top of another, a true overlap, back-to-back
        // intervals, the same time on a different year, month or day, a huge duration
        // overlapping from the start of the day, deletes past the end, at the head, at
        // the tail and in the middle, and an add after the shifts.
        directed_rows = '{
            del_row(8'd0, 1'b1, icrt_pkg::ST_EMPTY, 8'd0, 9'd0),
            del_row(8'd255, 1'b1, icrt_pkg::ST_EMPTY, 8'd0, 9'd0),
            add_row(6'd31, 4'd12, 14'd16383, 5'd23, 6'd59, 16'd65535,
                    1'b1, icrt_pkg::ST_ADDED, 8'd0, 9'd1),
            add_row(6'd32, 4'd1, 14'd2024, 5'd8, 6'd0, 16'd30,
                    1'b1, icrt_pkg::ST_INVALID, 8'd0, 9'd1),
            add_row(6'd1, 4'd13, 14'd2024, 5'd8, 6'd0, 16'd30,
                    1'b1, icrt_pkg::ST_INVALID, 8'd0, 9'd1),
            add_row(6'd1, 4'd1, 14'd2024, 5'd24, 6'd0, 16'd30,
                    1'b1, icrt_pkg::ST_INVALID, 8'd0, 9'd1),
            add_row(6'd1, 4'd1, 14'd2024, 5'd8, 6'd60, 16'd30,
                    1'b1, icrt_pkg::ST_INVALID, 8'd0, 9'd1),
            add_row(6'd63, 4'd15, 14'd16383, 5'd31, 6'd63, 16'd65535,
                    1'b1, icrt_pkg::ST_INVALID, 8'd0, 9'd1),
            add_row(6'd0, 4'd0, 14'd0, 5'd0, 6'd0, 16'd0,
                    1'b1, icrt_pkg::ST_ADDED, 8'd1, 9'd2),
            add_row(6'd0, 4'd0, 14'd0, 5'd0, 6'd0, 16'd0),
            add_row(6'd0, 4'd0, 14'd0, 5'd0, 6'd0, 16'd60),
            add_row(6'd0, 4'd0, 14'd0, 5'd0, 6'd30, 16'd10),
            add_row(6'd0, 4'd0, 14'd0, 5'd1, 6'd0, 16'd5),
            add_row(6'd0, 4'd0, 14'd1, 5'd0, 6'd30, 16'd10),
            add_row(6'd0, 4'd1, 14'd0, 5'd0, 6'd30, 16'd10),
            add_row(6'd1, 4'd0, 14'd0, 5'd0, 6'd30, 16'd10),
            add_row(6'd31, 4'd12, 14'd16383, 5'd0, 6'd0, 16'd65535),
            add_row(6'd31, 4'd12, 14'd16383, 5'd23, 6'd58, 16'd1),
            del_row(8'd200),
            del_row(8'd9),
            del_row(8'd0),
            del_row(8'd7),
            del_row(8'd2),
            add_row(6'd0, 4'd0, 14'd0, 5'd0, 6'd30, 16'd10),
            add_row(6'd15, 4'd6, 14'd8191, 5'd12, 6'd0, 16'd1)
        };

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (i = 0; i < NUM_DIRECTED; i++)
        begin
            send_transfer(directed_rows[i].req, directed_rows[i].has_answer,
                          directed_rows[i].answer);
            sender_pause();
        end

        // Random part: fill until the table is full, keep pushing while it is full,
        // then drain it with mostly deletes.
        for (i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (!reached_full)
            begin
                phase = LOAD_FILLING;
            end
            else if (items_since_full < AT_CAPACITY_ITEMS)
            begin
                phase = LOAD_AT_CAPACITY;
            end
            else
            begin
                phase = LOAD_DRAINING;
            end
            make_random_request(phase, req);
            send_transfer(req, 1'b0, '0);
            if (reached_full)
            begin
                items_since_full++;
            end
            sender_pause();
        end
        in_valid <= 1'b0;

        // Wait for every owed result, then keep running so that a stray extra result
        // would still be caught.
        while (answers_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (icrt_pkg::CAPACITY + 8) @(posedge clk);

        if (mismatch_count == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
